@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define GLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glt assertion failed");

`endif

@@ rtl/core/glt_pkg.sv @@
`timescale 1ns / 1ps
package glt_pkg;

  typedef struct packed {
    logic [10:0] day_in_period;
    logic [4:0]  period_number;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds_in;
  } glt_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [12:0] week_number;
    logic [19:0] time_of_week;
  } glt_out_t;

  // Day count stage -> divide stage.
  typedef struct packed {
    logic        vld;
    logic        date_ok;
    logic [15:0] days;
    logic [16:0] tod;
  } glt_stg1_t;

  // Divide stage -> time-of-week stage.
  typedef struct packed {
    logic        vld;
    logic        date_ok;
    logic [15:0] days;
    logic [12:0] quot;
    logic [16:0] tod;
  } glt_stg2_t;

  localparam logic [5:0]  LEAP_SECONDS_RESET = 6'd18;
  localparam logic [10:0] DAY_MAX            = 11'd1461;
  localparam logic [10:0] DAYS_LEAP_YEAR     = 11'd366;
  localparam logic [4:0]  PERIOD_2100        = 5'd27;
  // Days from the GPS epoch to January 1 of 1996.
  localparam logic [15:0] DAYS_EPOCH_TO_1996 = 16'd5839;
  localparam logic [15:0] DAYS_PER_PERIOD    = 16'd1461;
  // floor(x / 7) = (x * RECIP7) >> RECIP7_SHIFT for x below 104857.
  localparam logic [16:0] RECIP7             = 17'd74899;
  localparam int          RECIP7_SHIFT       = 19;
  localparam logic [19:0] SECS_IN_DAY        = 20'd86400;
  localparam logic [16:0] SECS_IN_HOUR       = 17'd3600;
  localparam logic [16:0] SECS_IN_MINUTE     = 17'd60;
  localparam logic [19:0] MOSCOW_OFFSET_SECS = 20'd10800;
  localparam logic [19:0] SECS_IN_WEEK       = 20'd604800;

endpackage

@@ rtl/core/glt_days.sv @@
`timescale 1ns / 1ps
module glt_days
  import glt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_beat,
  input  glt_in_t   in_data,
  output glt_stg1_t stg1
);

  glt_stg1_t stg1_r, stg1_nxt;
  logic [4:0] period_idx;
  logic       corr;

  always_comb begin
    period_idx = in_data.period_number - 5'd1;
    // 2100 is no leap year: drop one day from 2101 (day 367 of period 27) on.
    corr = (in_data.period_number > PERIOD_2100) ||
           ((in_data.period_number == PERIOD_2100) &&
            (in_data.day_in_period > DAYS_LEAP_YEAR));
    stg1_nxt.vld     = in_beat;
    stg1_nxt.date_ok = (in_data.period_number != 5'd0) &&
                       (in_data.day_in_period != 11'd0) &&
                       (in_data.day_in_period <= DAY_MAX);
    stg1_nxt.days    = DAYS_EPOCH_TO_1996 + 16'(period_idx) * DAYS_PER_PERIOD
                     + 16'(in_data.day_in_period) - 16'd1 - 16'(corr);
    stg1_nxt.tod     = 17'(in_data.hours) * SECS_IN_HOUR
                     + 17'(in_data.minutes) * SECS_IN_MINUTE
                     + 17'(in_data.seconds_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r.vld <= 1'b0;
    end else begin
      stg1_r.vld <= stg1_nxt.vld;
    end
    stg1_r.date_ok <= stg1_nxt.date_ok;
    stg1_r.days    <= stg1_nxt.days;
    stg1_r.tod     <= stg1_nxt.tod;
  end

  assign stg1 = stg1_r;

endmodule

@@ rtl/core/glt_div7.sv @@
`timescale 1ns / 1ps
module glt_div7
  import glt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  glt_stg1_t stg1,
  output glt_stg2_t stg2
);

  glt_stg2_t   stg2_r, stg2_nxt;
  logic [32:0] prod;

  always_comb begin
    prod = 33'(stg1.days) * 33'(RECIP7);
    stg2_nxt.vld     = stg1.vld;
    stg2_nxt.date_ok = stg1.date_ok;
    stg2_nxt.days    = stg1.days;
    stg2_nxt.quot    = prod[RECIP7_SHIFT +: 13];
    stg2_nxt.tod     = stg1.tod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg2_r.vld <= 1'b0;
    end else begin
      stg2_r.vld <= stg2_nxt.vld;
    end
    stg2_r.date_ok <= stg2_nxt.date_ok;
    stg2_r.days    <= stg2_nxt.days;
    stg2_r.quot    <= stg2_nxt.quot;
    stg2_r.tod     <= stg2_nxt.tod;
  end

  assign stg2 = stg2_r;

endmodule

@@ rtl/core/glt_tow.sv @@
`timescale 1ns / 1ps
module glt_tow
  import glt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  glt_stg2_t stg2,
  input  logic [5:0] leap_seconds,
  output logic      out_strobe,
  output glt_out_t  out_data
);

  logic        strobe_r, strobe_nxt;
  glt_out_t    data_r, data_nxt;
  logic [15:0] rem_full;
  logic [2:0]  dow;
  logic [19:0] sum;

  always_comb begin
    rem_full = stg2.days - ({stg2.quot, 3'b000} - 16'(stg2.quot));
    dow      = rem_full[2:0];
    sum      = 20'(leap_seconds) + 20'(dow) * SECS_IN_DAY + 20'(stg2.tod);
    strobe_nxt = stg2.vld;
    data_nxt   = '0;
    if (stg2.date_ok) begin
      data_nxt.valid_res = 1'b1;
      // Remove the Moscow offset and wrap into one week.
      priority if (sum < MOSCOW_OFFSET_SECS) begin
        data_nxt.time_of_week = sum + SECS_IN_WEEK - MOSCOW_OFFSET_SECS;
        data_nxt.week_number  = stg2.quot - 13'd1;
      end else if (sum >= SECS_IN_WEEK + MOSCOW_OFFSET_SECS) begin
        data_nxt.time_of_week = sum - SECS_IN_WEEK - MOSCOW_OFFSET_SECS;
        data_nxt.week_number  = stg2.quot + 13'd1;
      end else begin
        data_nxt.time_of_week = sum - MOSCOW_OFFSET_SECS;
        data_nxt.week_number  = stg2.quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

@@ rtl/core/glonass_to_gps_time_unit.sv @@
`timescale 1ns / 1ps
// GLONASS date and Moscow time of day to GPS week and time of week.
//
// Input channel: drive in_data and pulse start; a beat is taken at every
// rising edge with start high and busy low. busy stays low, so a new beat
// can be offered in every cycle.
// Result channel: each beat yields one result on out_data, shown for exactly
// one cycle with out_strobe high, after the beat has passed the register stages.
// Results leave in the order the beats came in. The receiver cannot stall;
// it must take each result in the cycle it is shown.
// Throughput: one beat per cycle. The pipeline holds three
// register stages (day count, divide by seven, time-of-week assembly).
// Configuration: cfg_wr_en writes cfg_wr_data into the leap-second register
// at the clock edge; write it only while no beat is in flight.
// Reset (rst_n low, synchronous): flush the pipeline so no result is shown,
// and load the leap-second register with 18.
// An out-of-range date gives valid_res low with zero week and time of week.
module glonass_to_gps_time_unit
  import glt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  glt_in_t    in_data,
  output logic       out_strobe,
  output glt_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  logic       in_beat;
  logic [5:0] leap_r, leap_nxt;
  glt_stg1_t  stg1;
  glt_stg2_t  stg2;

  // Fully pipelined: never hold off the sender.
  assign busy    = 1'b0;
  assign in_beat = start && !busy;

  // Leap-second register: load on a config write, hold otherwise.
  always_comb begin
    leap_nxt = cfg_wr_en ? cfg_wr_data : leap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= LEAP_SECONDS_RESET;
    end else begin
      leap_r <= leap_nxt;
    end
  end

  // Stage 1: check the date, count days since the GPS epoch, sum time of day.
  glt_days u_days (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .in_data (in_data),
    .stg1    (stg1)
  );

  // Stage 2: week number by reciprocal multiply.
  glt_div7 u_div7 (
    .clk   (clk),
    .rst_n (rst_n),
    .stg1  (stg1),
    .stg2  (stg2)
  );

  // Stage 3: day of week, offsets and week wrap into the result register.
  glt_tow u_tow (
    .clk          (clk),
    .rst_n        (rst_n),
    .stg2         (stg2),
    .leap_seconds (leap_r),
    .out_strobe   (out_strobe),
    .out_data     (out_data)
  );

endmodule

@@ rtl/core/glt_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glt_checker
  import glt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input glt_out_t out_data
);

  `GLT_ASSERT_IMP(a_no_phantom, clk, rst_n, out_strobe, $past(start && !busy, 3))
  `GLT_ASSERT_IMP(a_no_loss, clk, rst_n, $past(start && !busy, 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1), out_strobe)
  `GLT_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_strobe && !out_data.valid_res, (out_data.week_number == 13'd0) && (out_data.time_of_week == 20'd0))
  `GLT_ASSERT_IMP(a_tow_range, clk, rst_n, out_strobe, out_data.time_of_week < SECS_IN_WEEK)
  `GLT_ASSERT_NEXT(a_never_busy, clk, rst_n, 1'b1, !busy)

endmodule

bind glonass_to_gps_time_unit glt_checker u_glt_checker (.*);

@@ verif/glonass_to_gps_time_unit_tb.sv @@
`timescale 1ns / 1ps
module glonass_to_gps_time_unit_tb;
  import glt_pkg::*;

  // Track the expected GPS week and time of week for every beat taken, and
  // hold a private copy of the leap-second register.
  class glt_scoreboard;
    glt_out_t   gps_time_q[$];
    logic [5:0] leap_secs;
    int         fail_cnt;

    function new();
      leap_secs = LEAP_SECONDS_RESET;
      fail_cnt  = 0;
    endfunction

    function void set_leap(logic [5:0] v);
      leap_secs = v;
    endfunction

    // Gregorian leap years among years 1..n.
    function longint leap_years_upto(longint n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function glt_out_t gps_time_of(glt_in_t d);
      longint   day, per, yidx, doy, yr, days, wn, tow;
      glt_out_t r;
      r   = '0;
      day = d.day_in_period;
      per = d.period_number;
      if (per < 1 || day < 1 || day > 1461) return r;
      if (day <= 366) begin
        yidx = 0;
        doy  = day;
      end else if (day <= 731) begin
        yidx = 1;
        doy  = day - 366;
      end else if (day <= 1096) begin
        yidx = 2;
        doy  = day - 731;
      end else begin
        yidx = 3;
        doy  = day - 1096;
      end
      yr   = 1996 + 4 * (per - 1) + yidx;
      days = 361 + 365 * (yr - 1981)
           + (leap_years_upto(yr - 1) - leap_years_upto(1980)) + doy - 1;
      wn   = days / 7;
      tow  = longint'(leap_secs) + (days % 7) * 86400
           + (longint'(d.hours) - 3) * 3600 + longint'(d.minutes) * 60
           + longint'(d.seconds_in);
      if (tow < 0) begin
        tow += 604800;
        wn  -= 1;
      end else if (tow >= 604800) begin
        tow -= 604800;
        wn  += 1;
      end
      r.valid_res    = 1'b1;
      r.week_number  = wn[12:0];
      r.time_of_week = tow[19:0];
      return r;
    endfunction

    function void fail(string msg);
      fail_cnt++;
      if (fail_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void note_beat(glt_in_t d);
      gps_time_q.push_back(gps_time_of(d));
    endfunction

    function void check_result(glt_out_t got);
      glt_out_t want;
      bit       bad;
      if (gps_time_q.size() == 0) begin
        fail($sformatf("unexpected result vld=%0d wn=%0d tow=%0d",
                       got.valid_res, got.week_number, got.time_of_week));
        return;
      end
      want = gps_time_q.pop_front();
      bad  = 1'b0;
      if (got.valid_res    !== want.valid_res)    bad = 1'b1;
      if (got.week_number  !== want.week_number)  bad = 1'b1;
      if (got.time_of_week !== want.time_of_week) bad = 1'b1;
      if (bad)
        fail($sformatf("exp vld=%0d wn=%0d tow=%0d, got vld=%0d wn=%0d tow=%0d",
                       want.valid_res, want.week_number, want.time_of_week,
                       got.valid_res, got.week_number, got.time_of_week));
    endfunction

    function int pending();
      return gps_time_q.size();
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  glt_in_t    in_data     = '0;
  logic       out_strobe;
  glt_out_t   out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  glt_scoreboard sb = new();

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glonass_to_gps_time_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Sample at the edge, before the block's own updates land: a beat taken,
  // a result shown and a register write all count at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_beat(in_data);
      if (out_strobe) sb.check_result(out_data);
      if (cfg_wr_en) sb.set_leap(cfg_wr_data);
    end
  end

  // Offer one beat and hold it until taken. Leave start high so a following
  // beat can go out back to back without a glitch on start.
  task automatic send_beat(input glt_in_t d);
    start   <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Write the leap-second register with the pipeline drained.
  task automatic write_leap(input logic [5:0] v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly legal dates and times of day with random content; the rest is
  // raw noise over the full field widths, which hits invalid dates and
  // out-of-range times of day.
  function automatic glt_in_t random_beat();
    glt_in_t d;
    if ($urandom_range(0, 4) != 0) begin
      d.day_in_period = 11'($urandom_range(1, 1461));
      d.period_number = 5'($urandom_range(1, 31));
      d.hours         = 5'($urandom_range(0, 23));
      d.minutes       = 6'($urandom_range(0, 59));
      d.seconds_in    = 6'($urandom_range(0, 59));
    end else begin
      d.day_in_period = 11'($urandom);
      d.period_number = 5'($urandom);
      d.hours         = 5'($urandom);
      d.minutes       = 6'($urandom);
      d.seconds_in    = 6'($urandom);
    end
    return d;
  endfunction

  task automatic run_random(input int n, input bit with_gaps);
    repeat (n) begin
      if (with_gaps && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 4));
      send_beat(random_beat());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset leap value of 18 seconds.
    // Start of the first period and end of the last one.
    send_beat(glt_in_t'{11'd1,    5'd1,  5'd0,  6'd0,  6'd0});
    send_beat(glt_in_t'{11'd1461, 5'd31, 5'd23, 6'd59, 6'd59});
    // Invalid dates: day zero, day past the period, all ones, period zero.
    send_beat(glt_in_t'{11'd0,    5'd1,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd1462, 5'd5,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd2047, 5'd31, 5'd31, 6'd63, 6'd63});
    send_beat(glt_in_t'{11'd100,  5'd0,  5'd12, 6'd0,  6'd0});
    // Year boundaries inside a period.
    send_beat(glt_in_t'{11'd366,  5'd2,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd367,  5'd2,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd731,  5'd2,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd732,  5'd2,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd1096, 5'd3,  5'd12, 6'd0,  6'd0});
    send_beat(glt_in_t'{11'd1097, 5'd3,  5'd12, 6'd0,  6'd0});
    // Period holding 2100, which is not a leap year.
    send_beat(glt_in_t'{11'd60,   5'd27, 5'd0,  6'd0,  6'd0});
    send_beat(glt_in_t'{11'd1461, 5'd27, 5'd23, 6'd59, 6'd59});
    // Time of day out of range enters the sum as is.
    send_beat(glt_in_t'{11'd500,  5'd10, 5'd31, 6'd63, 6'd63});
    // Day 6 of period 1 is the last day of a GPS week: land exactly on the
    // week end (wraps to the next week) and one second short of it.
    send_beat(glt_in_t'{11'd6,    5'd1,  5'd26, 6'd59, 6'd42});
    send_beat(glt_in_t'{11'd6,    5'd1,  5'd26, 6'd59, 6'd41});
    // Day 7 starts a week: one second before it (wraps back) and at zero.
    send_beat(glt_in_t'{11'd7,    5'd1,  5'd2,  6'd59, 6'd41});
    send_beat(glt_in_t'{11'd7,    5'd1,  5'd2,  6'd59, 6'd42});

    // Random phases across leap settings, extremes first.
    write_leap(6'd0);
    run_random(90, 1'b1);
    write_leap(6'd63);
    run_random(90, 1'b1);
    write_leap(6'($urandom));
    run_random(90, 1'b1);
    write_leap(6'($urandom));
    run_random(90, 1'b1);
    // Last stretch: back-to-back beats, no gaps.
    write_leap(LEAP_SECONDS_RESET);
    run_random(90, 1'b0);

    // Drain, then wait out the pipeline to catch stray results.
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.fail("results still expected at end of run");

    if (sb.fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
